// ----- rtl/clik_pkg.sv -----
package clik_pkg;

    localparam int CordicStages = 16;
    localparam int GuardBits    = 4;
    // CORDIC datapath width: lengths up to 26 bits, 4 guard bits, growth 4 bits.
    localparam int CW = 34;
    localparam int ZW = 28;

    localparam logic signed [ZW-1:0] PiQ24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] PiThirdQ24 = 28'sd17569060;
    localparam logic [29:0]          InvGainQ30 = 30'd652032874;
    localparam logic [15:0]          InvSqrt3Q16 = 16'd37837;

    localparam logic [0:0] RegRadius = 1'b0;
    localparam logic [0:0] RegLimit  = 1'b1;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 28'sd13176795;
            1: v = 28'sd7778716;
            2: v = 28'sd4110060;
            3: v = 28'sd2086331;
            4: v = 28'sd1047214;
            5: v = 28'sd524117;
            6: v = 28'sd262123;
            7: v = 28'sd131069;
            default: v = (i < 24) ? (28'sd65536 >>> (i - 8)) : 28'sd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [15:0] theta;
        logic [15:0] phi;
        logic        ok;
    } t_seg_res;

endpackage

// ----- rtl/clik_if.sv -----
interface clik_in_if (input logic i_clk);
    logic               valid;
    logic               ready;
    logic signed [23:0] length_0;
    logic signed [23:0] length_1;
    logic signed [23:0] length_2;
    logic signed [23:0] length_3;
    logic signed [23:0] length_4;
    logic signed [23:0] length_5;
    modport source (output valid, length_0, length_1, length_2, length_3, length_4,
                    length_5, input ready);
    modport sink (input valid, length_0, length_1, length_2, length_3, length_4,
                  length_5, output ready);
endinterface

interface clik_out_if (input logic i_clk);
    logic               valid;
    logic               ready;
    logic        [15:0] theta_first;
    logic signed [15:0] phi_first;
    logic        [15:0] theta_second;
    logic signed [15:0] phi_second;
    modport source (output valid, theta_first, phi_first, theta_second, phi_second,
                    input ready);
    modport sink (input valid, theta_first, phi_first, theta_second, phi_second,
                  output ready);
endinterface

// ----- rtl/clik_solver.sv -----
// Pipelined solver for one segment: CORDIC vectoring, gain, limit and theta/phi.
// The pipeline advances only when i_en is high.
module clik_solver
    import clik_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [25:0] i_a,
    input  logic signed [25:0] i_b,
    input  logic               i_shift,
    input  logic [15:0]        i_radius,
    input  logic [15:0]        i_limit,
    output t_seg_res           o_res
);
    localparam int N = CordicStages;

    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic                 r_sh [0:N+2];
    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;

    always_comb begin
        n_x0 = CW'(i_a) <<< GuardBits;
        n_y0 = CW'(i_b) <<< GuardBits;
        n_z0 = '0;
        if (n_x0 < 0) begin
            n_z0 = (n_y0 >= 0) ? PiQ24 : -PiQ24;
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sh[0] <= i_shift;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[g+1] <= r_sh[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q24(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q24(g);
                end
            end
        end
    end

    // Gain stage, then limit/theta product, then rounding and saturation.
    logic [63:0]          r_prod;
    logic signed [ZW-1:0] r_za, r_zb, r_zc;
    logic [29:0]          r_mag;
    logic [45:0]          r_tp;
    logic [29:0]          r_tr;
    logic                 r_ok, r_ok2;
    logic [15:0]          r_theta, r_phi;
    logic                 r_okf;
    logic signed [ZW-1:0] n_zcl, n_zs;
    logic [29:0]          n_mag;
    logic [29:0]          n_t;

    always_comb begin
        n_zcl = r_z[N];
        if (n_zcl > PiQ24) n_zcl = PiQ24;
        if (n_zcl < -PiQ24) n_zcl = -PiQ24;
        n_mag = 30'((r_prod + 64'(1) * (64'd1 << 33)) >> 34);
        n_zs = r_zb - (r_sh[N+2] ? PiThirdQ24 : '0) + ZW'(2048);
        n_t = 30'((r_tp + 46'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= 64'(r_x[N][CW-2:0]) * 64'(InvGainQ30);
            r_za     <= n_zcl;
            r_sh[N+1] <= r_sh[N];
            r_mag    <= n_mag;
            r_zb     <= r_za;
            r_sh[N+2] <= r_sh[N+1];
            r_ok     <= n_mag > 30'(i_limit);
            r_tp     <= 46'(n_mag) * 46'(i_radius);
            r_zc     <= n_zs;
            r_tr     <= n_t;
            r_ok2    <= r_ok;
            r_okf    <= r_ok2;
            r_theta  <= !r_ok2 ? '0 : (r_tr > 30'd65535 ? 16'hFFFF : r_tr[15:0]);
            r_phi    <= !r_ok2 ? '0 : r_zc[27:12];
        end
    end

    assign o_res = '{theta: r_theta, phi: r_phi, ok: r_okf};
endmodule

// ----- rtl/cable_length_inverse_kinematics.sv -----
// Channel | dir | payload
// in      | in  | length_0..length_5, signed Q8.16
// out     | out | theta_first, phi_first, theta_second, phi_second
// One item enters per cycle unless the output stalls. An item passes
// through the first solver, the projection stages and then the second
// solver, two chained CORDIC pipelines. The whole pipeline advances
// together and freezes when the output holds an item that is not taken;
// reset clears only the valid bits and the configuration registers.
module cable_length_inverse_kinematics
    import clik_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    clik_in_if.sink     in_ch,
    clik_out_if.source  out_ch
);
    localparam int L1 = CordicStages + 5;
    localparam int D = 2 * L1 + 3;

    logic [15:0] r_radius, r_limit;
    logic [D-1:0] r_vld;
    logic en;

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd4096;
            r_limit  <= 16'd1;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegRadius: r_radius <= i_cfg_data;
                    RegLimit:  r_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) r_vld <= {r_vld[D-2:0], in_ch.valid};
        end
    end

    // Stage 0: differences and the 1/sqrt3 product for segment one.
    logic signed [25:0] r_d0;
    logic signed [41:0] r_bp;
    logic signed [23:0] r_l1 [0:L1];
    logic signed [23:0] r_l3 [0:L1];
    logic signed [23:0] r_l5 [0:L1];
    logic signed [25:0] r_p0 [0:L1];
    logic signed [25:0] r_pd [0:L1];
    logic signed [25:0] s1_a, s1_b;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0   <= 26'(in_ch.length_0);
            r_bp   <= (42'(in_ch.length_4) - 42'(in_ch.length_2)) *
                      $signed({1'b0, InvSqrt3Q16});
            r_l1[0] <= in_ch.length_1;
            r_l3[0] <= in_ch.length_3;
            r_l5[0] <= in_ch.length_5;
            r_p0[0] <= 26'(in_ch.length_0);
            r_pd[0] <= 26'(in_ch.length_4) - 26'(in_ch.length_2);
            for (int k = 0; k < L1; k++) begin
                r_l1[k+1] <= r_l1[k];
                r_l3[k+1] <= r_l3[k];
                r_l5[k+1] <= r_l5[k];
            end
            for (int k = 0; k < L1; k++) begin
                r_p0[k+1] <= r_p0[k];
                r_pd[k+1] <= r_pd[k];
            end
        end
    end

    assign s1_a = r_d0;
    assign s1_b = 26'((r_bp + 42'sd32768) >>> 16);

    t_seg_res res1;
    clik_solver u_seg1 (
        .i_clk(i_clk), .i_en(en), .i_a(s1_a), .i_b(s1_b), .i_shift(1'b0),
        .i_radius(r_radius), .i_limit(r_limit), .o_res(res1)
    );

    // Projection removal once segment one is known.
    logic signed [25:0] r_c1, r_c3, r_c5;
    logic signed [41:0] r_bp2;
    logic signed [25:0] r_c1b;
    t_seg_res r_res1 [0:L1+1];
    logic signed [25:0] d0x, dfx;

    assign d0x = r_p0[L1];
    assign dfx = r_pd[L1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (res1.ok) begin
                r_c1 <= 26'(r_l1[L1]) + ((dfx - d0x) >>> 1);
                r_c3 <= 26'(r_l3[L1]) + d0x;
                r_c5 <= 26'(r_l5[L1]) - ((d0x + dfx) >>> 1);
            end else begin
                r_c1 <= 26'(r_l1[L1]);
                r_c3 <= 26'(r_l3[L1]);
                r_c5 <= 26'(r_l5[L1]);
            end
            r_bp2   <= (42'(r_c5) - 42'(r_c3)) * $signed({1'b0, InvSqrt3Q16});
            r_c1b   <= r_c1;
            r_res1[0] <= res1;
            for (int k = 0; k < L1 + 1; k++) r_res1[k+1] <= r_res1[k];
        end
    end

    t_seg_res res2;
    clik_solver u_seg2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_c1b), .i_b(26'((r_bp2 + 42'sd32768) >>> 16)),
        .i_shift(1'b1), .i_radius(r_radius), .i_limit(r_limit), .o_res(res2)
    );

    assign out_ch.valid        = r_vld[D-1];
    assign out_ch.theta_first  = r_res1[L1+1].theta;
    assign out_ch.phi_first    = r_res1[L1+1].phi;
    assign out_ch.theta_second = res2.theta;
    assign out_ch.phi_second   = res2.phi;

`ifndef SYNTH
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.theta_first))
        else $error("output item changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipeline stalled with empty output");
`endif
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the two-segment cable inverse-kinematics block.
// A scoreboard class predicts each pose's bend angles and directions from the
// six cable length changes. Tasks drive the input channel at falling edges,
// and a monitor checks each accepted result at the rising edge.

import clik_pkg::*;

typedef struct {
    logic [15:0]        theta_first;
    logic signed [15:0] phi_first;
    logic [15:0]        theta_second;
    logic signed [15:0] phi_second;
} t_pose_result;

class kinematics_scoreboard;
    logic [15:0] radius_recip = 16'd4096;
    logic [15:0] zero_limit   = 16'd1;
    t_pose_result pending_poses[$];
    int errors = 0;
    int checked = 0;
    int singular_seen = 0;

    // Round to nearest, then floor-shift. SystemVerilog >>> on a signed
    // 64-bit value is already a floor shift.
    function automatic longint div_sqrt3(longint v);
        return (v * 37837 + 32768) >>> 16;
    endfunction

    // CORDIC vectoring. It gives the magnitude in length LSBs and the angle in Q.24.
    function automatic void vector_to_polar(longint a, longint b,
                                            output longint mag, output longint ang);
        longint x, y, z, xs, ys, step;
        x = a * 16;
        y = b * 16;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CordicStages && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = atan_q24(i);
            if (y >= 0) begin
                x += ys; y -= xs; z += step;
            end else begin
                x -= ys; y += xs; z -= step;
            end
        end
        if (z > 52707179) z = 52707179;
        if (z < -52707179) z = -52707179;
        mag = (x * 652032874 + (64'sd1 <<< 33)) >>> 34;
        ang = z;
    endfunction

    // This solves one segment. It returns 0 when the segment is singular.
    function automatic bit solve_segment(longint a, longint b, longint shift_q24,
                                         output logic [15:0] theta,
                                         output logic [15:0] phi);
        longint mag, ang, t;
        vector_to_polar(a, b, mag, ang);
        if (mag <= longint'(zero_limit)) begin
            theta = 0;
            phi = 0;
            singular_seen++;
            return 0;
        end
        t = (mag * longint'(radius_recip) + 32768) >>> 16;
        if (t > 65535) t = 65535;
        if (t < 0) t = 0;
        theta = t[15:0];
        phi = 16'((ang - shift_q24 + 2048) >>> 12);
        return 1;
    endfunction

    function void note_pose(logic signed [23:0] d[6]);
        t_pose_result r;
        longint l0, l1, l2, l3, l4, l5, diff, c1, c3, c5;
        logic [15:0] th, ph;
        l0 = d[0]; l1 = d[1]; l2 = d[2]; l3 = d[3]; l4 = d[4]; l5 = d[5];
        diff = l4 - l2;
        c1 = l1; c3 = l3; c5 = l5;
        if (solve_segment(l0, div_sqrt3(diff), 0, th, ph)) begin
            c1 = l1 + ((diff - l0) >>> 1);
            c3 = l3 + l0;
            c5 = l5 - ((l0 + diff) >>> 1);
        end
        r.theta_first = th;
        r.phi_first = ph;
        void'(solve_segment(c1, div_sqrt3(c5 - c3), 17569060, th, ph));
        r.theta_second = th;
        r.phi_second = ph;
        pending_poses.push_back(r);
    endfunction

    function void check_result(t_pose_result got);
        t_pose_result want;
        checked++;
        if (pending_poses.size() == 0) begin
            $display("%0t: result with no pose pending: th1=%0d ph1=%0d th2=%0d ph2=%0d",
                     $time, got.theta_first, got.phi_first, got.theta_second,
                     got.phi_second);
            errors++;
            return;
        end
        want = pending_poses.pop_front();
        if (got.theta_first !== want.theta_first) begin
            $display("%0t: theta_first expected %0d got %0d", $time,
                     want.theta_first, got.theta_first);
            errors++;
        end
        if (got.phi_first !== want.phi_first) begin
            $display("%0t: phi_first expected %0d got %0d", $time,
                     want.phi_first, got.phi_first);
            errors++;
        end
        if (got.theta_second !== want.theta_second) begin
            $display("%0t: theta_second expected %0d got %0d", $time,
                     want.theta_second, got.theta_second);
            errors++;
        end
        if (got.phi_second !== want.phi_second) begin
            $display("%0t: phi_second expected %0d got %0d", $time,
                     want.phi_second, got.phi_second);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int Latency  = 2 * (CordicStages + 5) + 3;
    localparam int IdleLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = RegRadius;
    logic [15:0] i_cfg_data = '0;

    clik_in_if  in_ch (i_clk);
    clik_out_if out_ch (i_clk);

    cable_length_inverse_kinematics dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    kinematics_scoreboard board = new();
    int  idle_cycles = 0;
    int  poses_sent = 0;
    bit  hold_output = 1'b0;   // This forces a long receiver stall while it is set.
    bit  stall_done = 1'b0;

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.length_0 = '0; in_ch.length_1 = '0; in_ch.length_2 = '0;
        in_ch.length_3 = '0; in_ch.length_4 = '0; in_ch.length_5 = '0;
        out_ch.ready = 1'b0;
    end

    // This returns a gap length. Most gaps are zero or short, and a few are long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls at random. During a forced hold it keeps ready low for
    // a long stretch that it counts itself, so the pipeline fills and backs up.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                out_ch.ready <= 1'b0;
                for (int k = 0; k < 300; k++) @(negedge i_clk);
                hold_output = 1'b0;
                stall_done = 1'b1;
                out_ch.ready <= 1'b1;
            end else if ((poses_sent / 200) % 2 == 1) begin
                // In this stretch the receiver is always ready.
                out_ch.ready <= 1'b1;
            end else begin
                g = gap_length();
                if (g == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    for (int k = 1; k < g; k++) @(negedge i_clk);
                end
            end
        end
    end

    // The monitor checks each result at the rising edge and also runs the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                t_pose_result got;
                got.theta_first  = out_ch.theta_first;
                got.phi_first    = out_ch.phi_first;
                got.theta_second = out_ch.theta_second;
                got.phi_second   = out_ch.phi_second;
                board.check_result(got);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: watchdog expired, %0d results still pending", $time,
                         board.pending_poses.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // This offers one pose and returns after the block accepts it. Valid stays
    // high when another pose follows with no gap.
    task automatic send_pose(logic signed [23:0] d[6], bit allow_gap);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.length_0 <= d[0]; in_ch.length_1 <= d[1]; in_ch.length_2 <= d[2];
        in_ch.length_3 <= d[3]; in_ch.length_4 <= d[4]; in_ch.length_5 <= d[5];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_pose(d);
        poses_sent++;
        @(negedge i_clk);
        g = allow_gap ? gap_length() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (board.pending_poses.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegRadius) board.radius_recip = value;
        else board.zero_limit = value;
    endtask

    // A random length. Full-scale, small and edge values are all mixed in.
    function automatic logic signed [23:0] random_length();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 16777215));
            1: return $signed(24'($urandom_range(0, 255))) - 24'sd128;
            2: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
            3: return ($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(0, 4194303))) - 24'sd2097152;
        endcase
    endfunction

    task automatic random_poses(int count);
        logic signed [23:0] d[6];
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            foreach (d[j]) d[j] = random_length();
            // Some poses have a singular first segment, so no projection is removed.
            if (kind == 0) begin
                d[0] = 0;
                d[4] = d[2];
            end
            // Some poses have a singular second segment after the projection.
            if (kind == 1) begin
                d[0] = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
                d[2] = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
                d[4] = d[2] + $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
                d[1] = -((d[4] - d[2] - d[0]) >>> 1);
                d[3] = -d[0];
                d[5] = (d[0] + d[4] - d[2]) >>> 1;
                d[5] = d[5] + d[3] - d[3];
            end
            // Some poses sit on the negative axis, where the angle is near plus or minus pi.
            if (kind == 2) begin
                d[0] = -$signed(24'($urandom_range(1, 4000000)));
                d[4] = d[2] + $signed(24'($urandom_range(0, 2))) - 24'sd1;
            end
            send_pose(d, (poses_sent / 200) % 2 == 0);
        end
    endtask

    initial begin
        logic signed [23:0] d[6];
        logic signed [23:0] edges[6];
        edges = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'shFFFFFF,
                  24'sh010000};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // These directed poses use the reset configuration: all zeros, each cable
        // alone at its extremes, exact axis directions, and both singular cases.
        foreach (d[j]) d[j] = 0;
        send_pose(d, 0);
        for (int c = 0; c < 6; c++) begin
            for (int e = 1; e < 3; e++) begin
                foreach (d[j]) d[j] = 0;
                d[c] = edges[e];
                send_pose(d, 0);
            end
        end
        foreach (d[j]) d[j] = 24'sh7FFFFF;
        send_pose(d, 1);
        foreach (d[j]) d[j] = 24'sh800000;
        send_pose(d, 1);
        d = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1};
        send_pose(d, 1);
        d = '{-24'sd70000, 24'sd5, 24'sd300, 24'sd0, 24'sd300, 24'sd0};
        send_pose(d, 1);
        d = '{-24'sd70000, 24'sd5, 24'sd301, 24'sd0, 24'sd300, 24'sd0};
        send_pose(d, 1);
        drain_and_settle();

        // This phase uses the extreme configuration: the largest radius reciprocal
        // saturates theta; the largest limit makes any segment up to 65535 singular.
        write_register(RegRadius, 16'hFFFF);
        write_register(RegLimit, 16'hFFFF);
        random_poses(120);
        drain_and_settle();

        write_register(RegRadius, 16'h0000);
        write_register(RegLimit, 16'h0000);
        random_poses(120);
        drain_and_settle();

        write_register(RegRadius, 16'd4096);
        write_register(RegLimit, 16'd1);
        random_poses(300);
        // The sender pauses here until every expected result has come.
        drain_and_settle();

        // The receiver holds off for a long stretch while poses keep coming.
        hold_output = 1'b1;
        random_poses(150);
        drain_and_settle();

        write_register(RegRadius, 16'($urandom_range(1, 65535)));
        write_register(RegLimit, 16'($urandom_range(0, 300)));
        random_poses(420);

        drain_and_settle();
        $display("Ran %0d poses and checked %0d results under five register settings.",
                 poses_sent, board.checked);
        $display("Singular segments predicted: %0d; receiver long stall done: %0d.",
                 board.singular_seen, stall_done);
        if (board.errors == 0 && board.pending_poses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/clik_pkg.sv
rtl/clik_if.sv
rtl/clik_solver.sv
rtl/cable_length_inverse_kinematics.sv
bench/testbench.sv
